/* hw/rtl/eso3_pkg.sv */
package eso3_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned WIDE_W      = 64;
  localparam int unsigned PROD_W      = 96;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned SHORT_SHIFT = 12;
  localparam int unsigned LONG_SHIFT  = 32;
  localparam int unsigned CAP_BIT     = 61;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_POSITION     = 3'd0,
    REG_GAIN_VELOCITY     = 3'd1,
    REG_GAIN_DISTURBANCE  = 3'd2,
    REG_STEP_SIZE         = 3'd3,
    REG_INVERSE_PLANT_GAIN = 3'd4
  } cfg_reg_e;

  localparam logic [DATA_W-1:0] RST_GAIN_POSITION      = 32'd405504;
  localparam logic [DATA_W-1:0] RST_GAIN_VELOCITY      = 32'd13381632;
  localparam logic [DATA_W-1:0] RST_GAIN_DISTURBANCE   = 32'd147197952;
  localparam logic [DATA_W-1:0] RST_STEP_SIZE          = 32'd4294967;
  localparam logic [DATA_W-1:0] RST_INVERSE_PLANT_GAIN = 32'd4291106;

  // products are clamped to +-2^61 before summing
  localparam logic [WIDE_W-1:0] PROD_CAP = 64'h2000_0000_0000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] measured_output;
    logic signed [DATA_W-1:0] controller_cmd;
  } sample_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] control_out;
    logic signed [DATA_W-1:0] est_position;
    logic signed [DATA_W-1:0] est_velocity;
    logic signed [DATA_W-1:0] est_disturbance;
  } result_t;

  typedef struct packed {
    logic                     start;
    logic                     long_shift;
    logic signed [WIDE_W-1:0] operand;
    logic [DATA_W-1:0]        coeff;
  } mul_cmd_t;

  typedef struct packed {
    logic                     done;
    logic signed [WIDE_W-1:0] product;
  } mul_rsp_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      return hi[DATA_W-1:0];
    end else if (v < lo) begin
      return lo[DATA_W-1:0];
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

/* hw/rtl/eso3_if.sv */
interface eso3_in_if;
  import eso3_pkg::*;

  logic    valid;
  logic    ready;
  sample_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface eso3_out_if;
  import eso3_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/extended_state_observer_3rd.sv */
// Third-order linear extended state observer, Q16.16 signals.
// sample_i (valid/ready) takes one transaction per control period: the plant
// output y and the controller command u0. result_o returns one transaction
// for each: the compensated control (u0 - z2)/b and the updated z0, z1, z2.
// The gains, step size and reciprocal plant gain sit behind a write-only
// register port (cfg_we_i, cfg_idx_i, cfg_data_i); write them while idle.
// The sequencer runs seven products through the single 32x32 multiplier,
// each as two partial products, then round/clamp and hand-back; the next
// input is taken only after the sequencer has returned to idle.
// sample_i.ready is high only while the sequencer is idle. A finished result
// waits in the output register; a new input may be accepted meanwhile, but
// its result is held back until the previous one is taken.
// Reset loads the default register values and clears the three states; no
// clearing pass is needed.
module extended_state_observer_3rd #(
  parameter int unsigned SIGNAL_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  eso3_in_if.sink                        sample_i,
  eso3_out_if.source                     result_o,
  input  logic                           cfg_we_i,
  input  logic [eso3_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [eso3_pkg::DATA_W-1:0]    cfg_data_i
);
  import eso3_pkg::*;

  localparam int unsigned EW = ((SIGNAL_WIDTH > DATA_W) ? SIGNAL_WIDTH : DATA_W) + 1;
  localparam logic signed [WIDE_W-1:0] Z_MAX = (64'sd1 <<< (SIGNAL_WIDTH - 1)) - 64'sd1;
  localparam logic signed [WIDE_W-1:0] Z_MIN = -Z_MAX - 64'sd1;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_CTL, S_P1, S_P2, S_P3, S_Q0, S_Q1, S_Q2, S_OUT
  } state_e;

  function automatic logic signed [SIGNAL_WIDTH-1:0] sat_state(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [WIDE_W-1:0] r;
    r = v;
    if (v > Z_MAX) begin
      r = Z_MAX;
    end else if (v < Z_MIN) begin
      r = Z_MIN;
    end
    return r[SIGNAL_WIDTH-1:0];
  endfunction

  logic [DATA_W-1:0] beta1_q, beta2_q, beta3_q, step_q, inv_b_q;

  state_e                         state_q;
  logic                           busy_q;
  logic signed [DATA_W-1:0]       y_q, cmd_q;
  logic signed [EW-1:0]           e_q, d_q;
  logic signed [WIDE_W-1:0]       r0_q, r1_q, r2_q;
  logic signed [DATA_W-1:0]       ctl_q;
  logic signed [SIGNAL_WIDTH-1:0] z0_q, z1_q, z2_q;
  logic                           out_valid_q;
  result_t                        out_q;
  logic                           out_load;

  mul_cmd_t                 mul_cmd;
  mul_rsp_t                 mul_rsp;
  logic                     mul_state;
  logic signed [WIDE_W-1:0] prod_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta1_q <= RST_GAIN_POSITION;
      beta2_q <= RST_GAIN_VELOCITY;
      beta3_q <= RST_GAIN_DISTURBANCE;
      step_q  <= RST_STEP_SIZE;
      inv_b_q <= RST_INVERSE_PLANT_GAIN;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GAIN_POSITION:      beta1_q <= cfg_data_i;
        REG_GAIN_VELOCITY:      beta2_q <= cfg_data_i;
        REG_GAIN_DISTURBANCE:   beta3_q <= cfg_data_i;
        REG_STEP_SIZE:          step_q  <= cfg_data_i;
        REG_INVERSE_PLANT_GAIN: inv_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign mul_state = (state_q == S_CTL) || (state_q == S_P1) || (state_q == S_P2) ||
                     (state_q == S_P3) || (state_q == S_Q0) || (state_q == S_Q1) ||
                     (state_q == S_Q2);

  always_comb begin
    mul_cmd.start      = mul_state && !busy_q;
    mul_cmd.long_shift = 1'b1;
    mul_cmd.operand    = WIDE_W'(e_q);
    mul_cmd.coeff      = step_q;
    unique case (state_q)
      S_CTL: begin
        mul_cmd.operand = WIDE_W'(d_q);
        mul_cmd.coeff   = inv_b_q;
      end
      S_P1: begin
        mul_cmd.long_shift = 1'b0;
        mul_cmd.coeff      = beta1_q;
      end
      S_P2: begin
        mul_cmd.long_shift = 1'b0;
        mul_cmd.coeff      = beta2_q;
      end
      S_P3: begin
        mul_cmd.long_shift = 1'b0;
        mul_cmd.coeff      = beta3_q;
      end
      S_Q0: mul_cmd.operand = r0_q;
      S_Q1: mul_cmd.operand = r1_q;
      S_Q2: mul_cmd.operand = r2_q;
      default: ;
    endcase
  end

  eso3_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mul_cmd),
    .rsp_o  (mul_rsp)
  );

  assign prod_s = $signed(mul_rsp.product);

  // output register takes a new result when empty or being drained this cycle
  assign out_load = (state_q == S_OUT) && (!out_valid_q || result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      busy_q      <= 1'b0;
      y_q         <= '0;
      cmd_q       <= '0;
      e_q         <= '0;
      d_q         <= '0;
      r0_q        <= '0;
      r1_q        <= '0;
      r2_q        <= '0;
      ctl_q       <= '0;
      z0_q        <= '0;
      z1_q        <= '0;
      z2_q        <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.valid && result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (mul_cmd.start) begin
        busy_q <= 1'b1;
      end else if (mul_rsp.done) begin
        busy_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (sample_i.valid) begin
            y_q     <= sample_i.data.measured_output;
            cmd_q   <= sample_i.data.controller_cmd;
            state_q <= S_DIFF;
          end
        end
        S_DIFF: begin
          e_q     <= EW'($signed(y_q)) - EW'($signed(z0_q));
          d_q     <= EW'($signed(cmd_q)) - EW'($signed(z2_q));
          state_q <= S_CTL;
        end
        S_CTL: if (mul_rsp.done) begin
          ctl_q   <= sat32(prod_s);
          state_q <= S_P1;
        end
        S_P1: if (mul_rsp.done) begin
          r0_q    <= WIDE_W'(z1_q) + prod_s;
          state_q <= S_P2;
        end
        S_P2: if (mul_rsp.done) begin
          r1_q    <= WIDE_W'(z2_q) + prod_s + WIDE_W'(d_q);
          state_q <= S_P3;
        end
        S_P3: if (mul_rsp.done) begin
          r2_q    <= prod_s;
          state_q <= S_Q0;
        end
        // old states are no longer needed once their own step is done
        S_Q0: if (mul_rsp.done) begin
          z0_q    <= sat_state(WIDE_W'(z0_q) + prod_s);
          state_q <= S_Q1;
        end
        S_Q1: if (mul_rsp.done) begin
          z1_q    <= sat_state(WIDE_W'(z1_q) + prod_s);
          state_q <= S_Q2;
        end
        S_Q2: if (mul_rsp.done) begin
          z2_q    <= sat_state(WIDE_W'(z2_q) + prod_s);
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_q.control_out     <= ctl_q;
            out_q.est_position    <= sat32(WIDE_W'(z0_q));
            out_q.est_velocity    <= sat32(WIDE_W'(z1_q));
            out_q.est_disturbance <= sat32(WIDE_W'(z2_q));
            state_q               <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign sample_i.ready = (state_q == S_IDLE);
  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

  a_idle_unit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_i.ready |-> !busy_q)
    else $error("input taken while the multiplier is still working");

  a_done_requested: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> busy_q)
    else $error("multiplier answered without a request");

  a_no_early_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_cmd.start |=> !mul_rsp.done)
    else $error("multiplier answered in the cycle after its start");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_o.valid) |-> $past(state_q == S_OUT))
    else $error("result raised outside the output step");

endmodule

/* hw/rtl/eso3_mul.sv */
module eso3_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  eso3_pkg::mul_cmd_t cmd_i,
  output eso3_pkg::mul_rsp_t rsp_o
);
  import eso3_pkg::*;

  localparam int unsigned SH_W = PROD_W - SHORT_SHIFT;
  localparam logic [PROD_W-1:0] RND_SHORT = PROD_W'(1) << (SHORT_SHIFT - 1);
  localparam logic [PROD_W-1:0] RND_LONG  = PROD_W'(1) << (LONG_SHIFT - 1);

  typedef enum logic [1:0] {M_IDLE, M_LO, M_HI, M_FIN} mstate_e;

  mstate_e                  state_q;
  logic [WIDE_W-1:0]        mag_q;
  logic                     neg_q;
  logic [DATA_W-1:0]        coeff_q;
  logic                     long_q;
  logic [PROD_W-1:0]        acc_q;
  logic                     done_q;
  logic signed [WIDE_W-1:0] product_q;

  logic [DATA_W-1:0]        mul_a;
  logic [WIDE_W-1:0]        prod;
  logic [PROD_W-1:0]        rnd;
  logic [SH_W-1:0]          shifted;
  logic                     over;
  logic [WIDE_W-1:0]        mag_res;
  logic [WIDE_W-1:0]        op_mag;

  // the one 32x32 multiplier: low half of the magnitude, then the high half
  assign mul_a = (state_q == M_LO) ? mag_q[DATA_W-1:0] : mag_q[WIDE_W-1:DATA_W];
  assign prod  = WIDE_W'(mul_a) * WIDE_W'(coeff_q);
  assign rnd   = long_q ? RND_LONG : RND_SHORT;

  assign shifted = long_q ? SH_W'(acc_q[PROD_W-1:LONG_SHIFT]) : acc_q[PROD_W-1:SHORT_SHIFT];
  assign over    = (|shifted[SH_W-1:CAP_BIT+1]) ||
                   (shifted[CAP_BIT] && (|shifted[CAP_BIT-1:0]));
  assign mag_res = over ? PROD_CAP : shifted[WIDE_W-1:0];

  assign op_mag = cmd_i.operand[WIDE_W-1] ? WIDE_W'(-cmd_i.operand) : WIDE_W'(cmd_i.operand);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= M_IDLE;
      mag_q     <= '0;
      neg_q     <= 1'b0;
      coeff_q   <= '0;
      long_q    <= 1'b0;
      acc_q     <= '0;
      done_q    <= 1'b0;
      product_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        M_IDLE: begin
          if (cmd_i.start) begin
            mag_q   <= op_mag;
            neg_q   <= cmd_i.operand[WIDE_W-1];
            coeff_q <= cmd_i.coeff;
            long_q  <= cmd_i.long_shift;
            state_q <= M_LO;
          end
        end
        M_LO: begin
          acc_q   <= PROD_W'(prod) + rnd;
          state_q <= M_HI;
        end
        M_HI: begin
          acc_q   <= acc_q + {prod, {(PROD_W-WIDE_W){1'b0}}};
          state_q <= M_FIN;
        end
        M_FIN: begin
          product_q <= neg_q ? -$signed(mag_res) : $signed(mag_res);
          done_q    <= 1'b1;
          state_q   <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = product_q;

endmodule
